// File: hdl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// Layered span resolver package
// Field widths, request and result codes, register indexes and the result
// item type shared by the resolver core.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int Y_BITS     = 15;
    localparam int X_BITS     = 16;
    localparam int Z_BITS     = 4;
    localparam int CL_BITS    = 4;
    localparam int COLOR_BITS = 16;
    localparam int ID_BITS    = 16;
    localparam int LWID_BITS  = 15;

    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 104;

    // Depth of the result queue in front of the output port.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    // Result kinds carried in the output tuser bit.
    localparam logic KIND_SPAN    = 1'b0;
    localparam logic KIND_COLLIDE = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [0:0] CFG_BG_COLOR   = 1'b1;

    localparam logic [LWID_BITS-1:0]  LINE_WIDTH_RST = 15'd160;
    localparam logic [COLOR_BITS-1:0] BG_COLOR_RST   = 16'd0;

    // Collide layer reported when the repair search finds no open layer.
    localparam logic [CL_BITS-1:0] COLLIDE_NONE = 4'd15;

    typedef struct packed {
        logic                     kind;
        logic [Y_BITS-1:0]        line_y;
        logic signed [X_BITS-1:0] x_start;
        logic signed [X_BITS-1:0] x_end;
        logic [COLOR_BITS-1:0]    color;
        logic [CL_BITS-1:0]       collide_first;
        logic [CL_BITS-1:0]       collide_second;
        logic [ID_BITS-1:0]       poly_first;
        logic [ID_BITS-1:0]       poly_second;
        logic                     last;
    } t_result;

endpackage

// File: hdl/lsr_ram.sv
// ----------------------------------------------------------------------------
// Layered span resolver RAM
// Generic single write port, single read port memory with registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/layered_span_resolver_core.sv
// ----------------------------------------------------------------------------
// Layered span resolver core
// Turns the sorted edge crossings of one scanline into colored spans and
// collision events, tracking open depth layers and collide layers.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_axis channel: an edge crossing (tuser low) or an end
// of scanline (tuser high). Crossings of one line come in rising x order,
// followed by one end-of-line item. Each item yields zero, one or two result
// items on the m_axis channel; tlast marks the final result of an input item.
// The per-layer colors and per-collide-layer polygon ids live in small
// synchronous RAMs; the open masks, top layer and tracked collide pair are
// held in flip-flops and updated in the cycle an item is accepted.
// Each accepted item passes the capture stage and then the result queue.
// Throughput is one item per cycle while the receiver is ready and each item
// yields at most one result; one with two results holds the output for both.
// The color RAM read issued when the top layer closes returns in the next
// cycle and is forwarded to the next item, so it costs no stall.
// Results wait in a four-entry queue; when the receiver stalls, input is
// accepted until the queue and the capture stage together could overflow.
// Reset clears all layer and collide state and loads line_width 160 and
// background color 0. The user must write the configuration only while no item
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module layered_span_resolver_core
    import lsr_pkg::*;
#(
    parameter int NUM_LAYERS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write port.
    input  logic                     i_cfg_wr_en,
    input  logic [0:0]               i_cfg_addr,
    input  logic [COLOR_BITS-1:0]    i_cfg_wr_data,
    // Input items.
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata, from bit 0: scan_y[15], edge_x[16], layer_z[4], collide_valid[1],
    // collide_layer[4], poly_color[16], poly_id[16].
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: req_type.
    input  logic                     s_axis_tuser,
    // Result items.
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata, from bit 0: line_y[15], x_start[16], x_end[16], slice_color[16],
    // collide_first[4], collide_second[4], poly_first[16], poly_second[16],
    // one zero pad bit.
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // tuser: out_kind.
    output logic                     m_axis_tuser,
    output logic                     m_axis_tlast
);

    localparam int LW = $clog2(NUM_LAYERS);
    localparam int CW = $clog2(NUM_LAYERS + 1);
    localparam logic [NUM_LAYERS-1:0] ONE_HOT0 = NUM_LAYERS'(1);

    // Reduces a four-bit layer number modulo the layer count.
    function automatic logic [LW-1:0] f_mod(input logic [3:0] v);
        logic [5:0] t;
        t = {2'b00, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= 6'(NUM_LAYERS)) begin
                t = t - 6'(NUM_LAYERS);
            end
        end
        return LW'(t);
    endfunction

    // Highest set bit of a mask; the top bit of the result flags a hit.
    function automatic logic [LW:0] f_top(input logic [NUM_LAYERS-1:0] m);
        logic [LW:0] r;
        r = '0;
        for (int k = 0; k < NUM_LAYERS; k++) begin
            if (m[k]) begin
                r = {1'b1, LW'(k)};
            end
        end
        return r;
    endfunction

    // Highest set bit as a collide layer number; none gives COLLIDE_NONE.
    function automatic logic [CL_BITS-1:0] f_top4(input logic [NUM_LAYERS-1:0] m);
        logic [LW:0] r;
        r = f_top(m);
        return r[LW] ? CL_BITS'(32'(r[LW-1:0])) : COLLIDE_NONE;
    endfunction

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic                     in_req;
    logic [Y_BITS-1:0]        in_y;
    logic signed [X_BITS-1:0] in_x;
    logic [Z_BITS-1:0]        in_z;
    logic                     in_cv;
    logic [CL_BITS-1:0]       in_ci;
    logic [COLOR_BITS-1:0]    in_color;
    logic [ID_BITS-1:0]       in_pid;

    assign in_req   = s_axis_tuser;
    assign in_y     = s_axis_tdata[14:0];
    assign in_x     = $signed(s_axis_tdata[30:15]);
    assign in_z     = s_axis_tdata[34:31];
    assign in_cv    = s_axis_tdata[35];
    assign in_ci    = s_axis_tdata[39:36];
    assign in_color = s_axis_tdata[55:40];
    assign in_pid   = s_axis_tdata[71:56];

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Configuration and scanline state
    // ------------------------------------------------------------------
    logic [LWID_BITS-1:0]     r_line_width;
    logic [COLOR_BITS-1:0]    r_bg_color;

    logic [NUM_LAYERS-1:0]    r_lopen,     n_lopen;
    logic [LW-1:0]            r_top,       n_top;
    logic                     r_vis_valid, n_vis_valid;
    logic [COLOR_BITS-1:0]    r_vis_color, n_vis_color;
    logic                     r_vis_pend,  n_vis_pend;
    logic [NUM_LAYERS-1:0]    r_copen,     n_copen;
    logic [CW-1:0]            r_ccount,    n_ccount;
    logic [CL_BITS-1:0]       r_ca,        n_ca;
    logic [CL_BITS-1:0]       r_cb,        n_cb;
    logic signed [X_BITS-1:0] r_prev_x,    n_prev_x;

    // Capture stage: results of the item accepted in the previous cycle.
    logic                     r_s2_valid;
    logic                     r_s2_span,    n_s2_span;
    logic                     r_s2_evt,     n_s2_evt;
    logic [Y_BITS-1:0]        r_s2_y;
    logic signed [X_BITS-1:0] r_s2_span_xs, n_s2_span_xs;
    logic signed [X_BITS-1:0] r_s2_span_xe, n_s2_span_xe;
    logic [COLOR_BITS-1:0]    r_s2_color,   n_s2_color;
    logic signed [X_BITS-1:0] r_s2_evt_xs;
    logic signed [X_BITS-1:0] r_s2_evt_xe;
    logic [CL_BITS-1:0]       r_s2_ca;
    logic [CL_BITS-1:0]       r_s2_cb;

    // ------------------------------------------------------------------
    // Table memories. The polygon id table is kept twice so that both
    // members of the tracked collide pair can be read in one cycle.
    // ------------------------------------------------------------------
    logic                  col_we;
    logic [LW-1:0]         col_raddr;
    logic [COLOR_BITS-1:0] col_rdata;
    logic                  poly_we;
    logic [ID_BITS-1:0]    poly_rdata_a;
    logic [ID_BITS-1:0]    poly_rdata_b;

    logic [LW-1:0]         z_idx;
    logic [LW-1:0]         ci_idx;
    logic [NUM_LAYERS-1:0] mz;
    logic [NUM_LAYERS-1:0] mi;
    logic [NUM_LAYERS-1:0] lopen_tog;
    logic [LW:0]           lopen_top;

    assign z_idx     = f_mod(in_z);
    assign ci_idx    = f_mod(in_ci);
    assign mz        = ONE_HOT0 << z_idx;
    assign mi        = in_cv ? (ONE_HOT0 << ci_idx) : '0;
    assign lopen_tog = r_lopen ^ mz;
    assign lopen_top = f_top(lopen_tog);
    assign col_raddr = lopen_top[LW-1:0];

    lsr_ram #(.WIDTH(COLOR_BITS), .DEPTH(NUM_LAYERS)) u_color_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_we),
        .i_wr_addr (z_idx),
        .i_wr_data (in_color),
        .i_rd_addr (col_raddr),
        .o_rd_data (col_rdata)
    );

    lsr_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_LAYERS)) u_poly_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (poly_we),
        .i_wr_addr (ci_idx),
        .i_wr_data (in_pid),
        .i_rd_addr (f_mod(r_ca)),
        .o_rd_data (poly_rdata_a)
    );

    lsr_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_LAYERS)) u_poly_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (poly_we),
        .i_wr_addr (ci_idx),
        .i_wr_data (in_pid),
        .i_rd_addr (f_mod(r_cb)),
        .o_rd_data (poly_rdata_b)
    );

    // ------------------------------------------------------------------
    // Item processing. The visible color forwarded from the color RAM is
    // the one left by the previous item when that item closed the top layer.
    // ------------------------------------------------------------------
    logic signed [X_BITS-1:0] lw_s;
    logic [COLOR_BITS-1:0]    eff_color;
    logic [CL_BITS-1:0]       ci4;

    assign lw_s      = $signed({1'b0, r_line_width});
    assign eff_color = r_vis_pend ? col_rdata : r_vis_color;
    assign ci4       = CL_BITS'(32'(ci_idx));

    always_comb begin
        n_lopen      = r_lopen;
        n_top        = r_top;
        n_vis_valid  = r_vis_valid;
        n_vis_color  = eff_color;
        n_vis_pend   = 1'b0;
        n_copen      = r_copen;
        n_ccount     = r_ccount;
        n_ca         = r_ca;
        n_cb         = r_cb;
        n_prev_x     = r_prev_x;
        n_s2_span    = 1'b0;
        n_s2_evt     = 1'b0;
        n_s2_span_xs = (r_prev_x > 16'sd0) ? r_prev_x : 16'sd0;
        n_s2_span_xe = lw_s;
        n_s2_color   = r_bg_color;
        col_we       = 1'b0;
        poly_we      = 1'b0;

        if (accept) begin
            if (in_req == REQ_EOL) begin
                // Final background span, then a clean slate for the next line.
                n_s2_span   = r_prev_x < lw_s;
                n_lopen     = '0;
                n_top       = '0;
                n_vis_valid = 1'b0;
                n_vis_color = '0;
                n_copen     = '0;
                n_ccount    = '0;
                n_ca        = '0;
                n_cb        = '0;
                n_prev_x    = '0;
            end else begin
                n_s2_span    = (in_x > 16'sd0) && (r_prev_x < lw_s);
                n_s2_evt     = (in_x > 16'sd0) && (r_ccount > CW'(1));
                n_s2_span_xe = (in_x < lw_s) ? in_x : lw_s;
                n_s2_color   = r_vis_valid ? eff_color : r_bg_color;
                n_prev_x     = in_x;
                n_lopen      = lopen_tog;

                if ((lopen_tog & mz) != '0) begin
                    // The layer opens: remember its color, maybe it is on top.
                    col_we = 1'b1;
                    if (!r_vis_valid || (z_idx > r_top)) begin
                        n_top       = z_idx;
                        n_vis_color = in_color;
                        n_vis_valid = 1'b1;
                    end
                    if (mi != '0) begin
                        poly_we = 1'b1;
                        if ((r_copen & mi) == '0) begin
                            n_copen  = r_copen | mi;
                            n_ccount = r_ccount + CW'(1);
                            if (n_ccount == CW'(1)) begin
                                n_ca = ci4;
                            end else if (n_ccount == CW'(2)) begin
                                n_cb = ci4;
                            end
                        end
                    end
                end else begin
                    // The layer closes. Closing the top layer re-picks the
                    // top and fetches its color from the RAM.
                    if (r_vis_valid && (z_idx == r_top)) begin
                        if (lopen_top[LW]) begin
                            n_top       = lopen_top[LW-1:0];
                            n_vis_valid = 1'b1;
                            n_vis_pend  = 1'b1;
                        end else begin
                            n_vis_valid = 1'b0;
                            n_vis_color = '0;
                        end
                    end
                    if ((r_copen & mi) != '0) begin
                        n_copen  = r_copen ^ mi;
                        n_ccount = r_ccount - CW'(1);
                        // The tracked pair is repaired only when the open
                        // count falls to one or two.
                        if ((n_ccount == CW'(1)) && (ci4 == r_ca)) begin
                            n_ca = r_cb;
                        end else if (n_ccount == CW'(2)) begin
                            if (ci4 == r_ca) begin
                                n_ca = f_top4(n_copen ^ (ONE_HOT0 << f_mod(r_cb)));
                            end else if (ci4 == r_cb) begin
                                n_cb = f_top4(n_copen ^ (ONE_HOT0 << f_mod(r_ca)));
                            end
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW:0]     r_fcnt;
    logic [1:0]           s2_n;
    logic [1:0]           push_n;
    logic                 pop;
    t_result              res_span;
    t_result              res_evt;
    t_result              head;

    assign s2_n   = r_s2_valid ? ({1'b0, r_s2_span} + {1'b0, r_s2_evt}) : 2'd0;
    assign push_n = s2_n;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_fcnt + (FIFO_AW + 1)'(s2_n)) <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);

    always_comb begin
        res_span                = '0;
        res_span.kind           = KIND_SPAN;
        res_span.line_y         = r_s2_y;
        res_span.x_start        = r_s2_span_xs;
        res_span.x_end          = r_s2_span_xe;
        res_span.color          = r_s2_color;
        res_span.last           = !r_s2_evt;

        res_evt                 = '0;
        res_evt.kind            = KIND_COLLIDE;
        res_evt.line_y          = r_s2_y;
        res_evt.x_start         = r_s2_evt_xs;
        res_evt.x_end           = r_s2_evt_xe;
        res_evt.collide_first   = r_s2_ca;
        res_evt.collide_second  = r_s2_cb;
        res_evt.poly_first      = poly_rdata_a;
        res_evt.poly_second     = poly_rdata_b;
        res_evt.last            = 1'b1;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_bg_color   <= BG_COLOR_RST;
            r_lopen      <= '0;
            r_top        <= '0;
            r_vis_valid  <= 1'b0;
            r_vis_color  <= '0;
            r_vis_pend   <= 1'b0;
            r_copen      <= '0;
            r_ccount     <= '0;
            r_ca         <= '0;
            r_cb         <= '0;
            r_prev_x     <= '0;
            r_s2_valid   <= 1'b0;
            r_s2_span    <= 1'b0;
            r_s2_evt     <= 1'b0;
            r_wp         <= '0;
            r_rp         <= '0;
            r_fcnt       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_LINE_WIDTH: r_line_width <= i_cfg_wr_data[LWID_BITS-1:0];
                    CFG_BG_COLOR:   r_bg_color   <= i_cfg_wr_data;
                    default:        r_bg_color   <= r_bg_color;
                endcase
            end
            r_lopen     <= n_lopen;
            r_top       <= n_top;
            r_vis_valid <= n_vis_valid;
            r_vis_color <= n_vis_color;
            r_vis_pend  <= n_vis_pend;
            r_copen     <= n_copen;
            r_ccount    <= n_ccount;
            r_ca        <= n_ca;
            r_cb        <= n_cb;
            r_prev_x    <= n_prev_x;
            r_s2_valid  <= accept;
            r_s2_span   <= n_s2_span;
            r_s2_evt    <= n_s2_evt;
            r_wp        <= r_wp + FIFO_AW'(push_n);
            r_rp        <= r_rp + FIFO_AW'(pop);
            r_fcnt      <= r_fcnt + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_y       <= in_y;
            r_s2_span_xs <= n_s2_span_xs;
            r_s2_span_xe <= n_s2_span_xe;
            r_s2_color   <= n_s2_color;
            r_s2_evt_xs  <= r_prev_x;
            r_s2_evt_xe  <= in_x;
            r_s2_ca      <= r_ca;
            r_s2_cb      <= r_cb;
        end
        if (r_s2_valid) begin
            if (r_s2_span) begin
                r_fifo[r_wp] <= res_span;
                if (r_s2_evt) begin
                    r_fifo[r_wp + FIFO_AW'(1)] <= res_evt;
                end
            end else if (r_s2_evt) begin
                r_fifo[r_wp] <= res_evt;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output port
    // ------------------------------------------------------------------
    assign head          = r_fifo[r_rp];
    assign m_axis_tvalid = r_fcnt != '0;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {1'b0, head.poly_second, head.poly_first,
                            head.collide_second, head.collide_first, head.color,
                            head.x_end, head.x_start, head.line_y};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fcnt + (FIFO_AW + 1)'(s2_n)) <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_visible_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vis_valid == (r_lopen != '0))
        else $error("visible flag disagrees with open layer mask");

    a_top_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vis_valid |-> r_lopen[r_top])
        else $error("top layer is not open");

    a_collide_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_copen) == int'(r_ccount))
        else $error("collide count disagrees with collide mask");

    a_pend_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vis_pend |-> $past(accept))
        else $error("color fetch pending without an accepted item");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Layered span resolver core testbench
// Streams sorted edge crossings and end-of-line items into the resolver. A
// behavioral copy of the span and collision logic predicts the results but for
// typed rows; each result on the output is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top
    import lsr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch without any handshake before the run is called hung.
    // The slowest legal stretch is the long receiver hold-off plus a long
    // receiver stall, a long sender gap and a drain pause, well under this.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 210;
    localparam int NUM_PHASES      = 8;
    // Cycles to let pass once the last expected result has arrived, so that
    // items which produce no result have left the pipeline too.
    localparam int DRAIN_CYCLES    = 8;

    // One input item: the request bit, then the tdata fields in bus order from bit 0.
    typedef struct packed {
        logic                     req;
        logic [Y_BITS-1:0]        y;
        logic signed [X_BITS-1:0] x;
        logic [Z_BITS-1:0]        z;
        logic                     cv;
        logic [CL_BITS-1:0]       ci;
        logic [COLOR_BITS-1:0]    color;
        logic [ID_BITS-1:0]       id;
    } t_item;

    // A stimulus row. When n_typed is 0 or 1 the expected output is written
    // into the row (no result, or one span); otherwise the span predictor
    // supplies it.
    typedef struct {
        t_item                    it;
        int                       n_typed;
        int                       xs;
        int                       xe;
        logic [COLOR_BITS-1:0]    col;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [0:0]               cfg_addr = CFG_LINE_WIDTH;
    logic [COLOR_BITS-1:0]    cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [IN_DATA_BITS-1:0]  s_data = '0;
    logic                     s_user = REQ_EDGE;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_data;
    logic                     m_user;
    logic                     m_last;

    layered_span_resolver_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Span predictor state: a private copy of the registers and of the layer
    // and collide tracking held by the block.
    // ------------------------------------------------------------------------
    logic [LWID_BITS-1:0]     line_width_q;
    logic [COLOR_BITS-1:0]    bg_color_q;
    logic [15:0]              layer_open;
    logic [COLOR_BITS-1:0]    layer_color [16];
    int                       top_z;
    logic [COLOR_BITS-1:0]    vis_color;
    logic                     vis_valid;
    logic [15:0]              collide_open;
    int                       collide_cnt;
    logic [CL_BITS-1:0]       pair_a;
    logic [CL_BITS-1:0]       pair_b;
    logic [ID_BITS-1:0]       collide_id [16];
    logic signed [X_BITS-1:0] prev_x;

    t_result pending_results[$];
    int      errors = 0;
    int      n_sent = 0;
    bit      no_gap = 1'b0;
    int      burst_until = 0;
    bit      hold_off_req = 1'b0;
    t_row    plan[$];

    function automatic int highest_set(logic [15:0] m);
        int r;
        r = -1;
        for (int k = 0; k < 16; k++)
            if (m[k]) r = k;
        return r;
    endfunction

    function automatic t_result make_result(logic kind, logic [Y_BITS-1:0] y, int xs,
                                            int xe, logic [COLOR_BITS-1:0] col,
                                            logic [CL_BITS-1:0] fa, logic [CL_BITS-1:0] fb,
                                            logic [ID_BITS-1:0] pa, logic [ID_BITS-1:0] pb);
        t_result r;
        r.kind           = kind;
        r.line_y         = y;
        r.x_start        = xs[X_BITS-1:0];
        r.x_end          = xe[X_BITS-1:0];
        r.color          = col;
        r.collide_first  = fa;
        r.collide_second = fb;
        r.poly_first     = pa;
        r.poly_second    = pb;
        r.last           = 1'b0;
        return r;
    endfunction

    task automatic clear_line_state();
        layer_open   = '0;
        top_z        = -1;
        vis_color    = '0;
        vis_valid    = 1'b0;
        collide_open = '0;
        collide_cnt  = 0;
        pair_a       = '0;
        pair_b       = '0;
        prev_x       = '0;
    endtask

    // Works out the results of one accepted item and advances the predictor.
    task automatic resolve_item(input t_item r, output t_result res0,
                                output t_result res1, output int n);
        t_result res [2];
        int      lw;
        int      px;
        int      xv;
        int      t;
        n  = 0;
        lw = int'(line_width_q);
        px = int'(prev_x);
        xv = int'(r.x);
        res[0] = make_result(KIND_SPAN, '0, 0, 0, '0, '0, '0, '0, '0);
        res[1] = res[0];
        if (r.req == REQ_EOL) begin
            // The rest of the line is background, unless the line is used up.
            if (px < lw) begin
                res[0] = make_result(KIND_SPAN, r.y, (px > 0) ? px : 0, lw, bg_color_q,
                                     '0, '0, '0, '0);
                n = 1;
            end
            clear_line_state();
        end else begin
            if (xv > 0) begin
                if (px < lw) begin
                    res[n] = make_result(KIND_SPAN, r.y, (px > 0) ? px : 0,
                                         (xv < lw) ? xv : lw,
                                         vis_valid ? vis_color : bg_color_q,
                                         '0, '0, '0, '0);
                    n++;
                end
                // Collision events use the raw x range, without clamping.
                if (collide_cnt > 1) begin
                    res[n] = make_result(KIND_COLLIDE, r.y, px, xv, '0, pair_a, pair_b,
                                         collide_id[pair_a], collide_id[pair_b]);
                    n++;
                end
            end
            prev_x = r.x;
            layer_open[r.z] = ~layer_open[r.z];
            if (layer_open[r.z]) begin
                layer_color[r.z] = r.color;
                if (int'(r.z) > top_z) begin
                    top_z     = int'(r.z);
                    vis_color = r.color;
                    vis_valid = 1'b1;
                end
                if (r.cv) begin
                    collide_id[r.ci] = r.id;
                    if (!collide_open[r.ci]) begin
                        collide_open[r.ci] = 1'b1;
                        collide_cnt++;
                        if (collide_cnt == 1) pair_a = r.ci;
                        else if (collide_cnt == 2) pair_b = r.ci;
                    end
                end
            end else begin
                if (int'(r.z) == top_z) begin
                    top_z = highest_set(layer_open);
                    if (top_z >= 0) begin
                        vis_color = layer_color[top_z];
                        vis_valid = 1'b1;
                    end else begin
                        vis_color = '0;
                        vis_valid = 1'b0;
                    end
                end
                if (r.cv && collide_open[r.ci]) begin
                    collide_open[r.ci] = 1'b0;
                    collide_cnt--;
                    // The tracked pair is only repaired when the count falls to
                    // one or two; with more layers open it may name a closed one.
                    if (collide_cnt == 1 && r.ci == pair_a) begin
                        pair_a = pair_b;
                    end else if (collide_cnt == 2) begin
                        if (r.ci == pair_a) begin
                            t      = highest_set(collide_open ^ (16'd1 << pair_b));
                            pair_a = t[CL_BITS-1:0];
                        end else if (r.ci == pair_b) begin
                            t      = highest_set(collide_open ^ (16'd1 << pair_a));
                            pair_b = t[CL_BITS-1:0];
                        end
                    end
                end
            end
        end
        if (n > 0) res[n-1].last = 1'b1;
        res0 = res[0];
        res1 = res[1];
    endtask

    // ------------------------------------------------------------------------
    // Input side. Each item is presented at a falling edge, optionally after
    // an idle gap, and held until the rising edge where tready is seen high.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_gap || n_sent < burst_until) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic offer(input t_row row);
        int      gap;
        int      n;
        t_result a;
        t_result b;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {row.it.id, row.it.color, row.it.ci, row.it.cv, row.it.z,
                    row.it.x, row.it.y};
        s_user  <= row.it.req;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        n_sent++;
        resolve_item(row.it, a, b, n);
        if (row.n_typed >= 0) begin
            // The typed expectation replaces the prediction for this row.
            if (row.n_typed == 1) begin
                a      = make_result(KIND_SPAN, row.it.y, row.xs, row.xe, row.col,
                                     '0, '0, '0, '0);
                a.last = 1'b1;
                pending_results.push_back(a);
            end
        end else begin
            if (n > 0) pending_results.push_back(a);
            if (n > 1) pending_results.push_back(b);
        end
    endtask

    // Drops tvalid, waits for every expected result and lets the pipeline
    // empty, so that registers may be written.
    task automatic wait_idle();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [LWID_BITS-1:0] lw, input logic [COLOR_BITS-1:0] bg);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_LINE_WIDTH;
        // The top bit lies above the register and must be ignored.
        cfg_wr_data <= {1'($urandom_range(0, 1)), lw};
        @(negedge i_clk);
        cfg_addr    <= CFG_BG_COLOR;
        cfg_wr_data <= bg;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        line_width_q = lw;
        bg_color_q   = bg;
    endtask

    function automatic t_item crossing(int y, int x, int z, bit cv, int ci, int col, int id);
        t_item it;
        it.req   = REQ_EDGE;
        it.y     = y[Y_BITS-1:0];
        it.x     = x[X_BITS-1:0];
        it.z     = z[Z_BITS-1:0];
        it.cv    = cv;
        it.ci    = ci[CL_BITS-1:0];
        it.color = col[COLOR_BITS-1:0];
        it.id    = id[ID_BITS-1:0];
        return it;
    endfunction

    function automatic t_item end_of_line(int y);
        t_item it;
        it     = crossing(y, 0, 0, 1'b0, 0, 0, 0);
        it.req = REQ_EOL;
        return it;
    endfunction

    task automatic add_row(input t_item it, input int n_typed, input int xs = 0,
                           input int xe = 0, input int col = 0);
        t_row row;
        row.it      = it;
        row.n_typed = n_typed;
        row.xs      = xs;
        row.xe      = xe;
        row.col     = col[COLOR_BITS-1:0];
        plan.push_back(row);
    endtask

    // Directed part, run with the reset values: line width 160, background 0.
    task automatic build_plan();
        // A bare end of line after reset draws the whole line in background.
        add_row(end_of_line(0), 1, 0, 160, 0);
        // Crossings at or left of 0 draw nothing but still open their layers.
        add_row(crossing(0, -32768, 3, 1, 2, 'h1234, 'hA001), 0);
        add_row(crossing(0, 0, 15, 1, 15, 'hFFFF, 'hFFFF), 0);
        // Two collide layers are open at this point, so a collision follows.
        add_row(crossing(0, 50, 0, 0, 9, 'h0001, 'h0000), -1);
        add_row(crossing(0, 100, 15, 1, 15, 'hFFFF, 'hFFFF), -1);
        // Span end clamped to the line width.
        add_row(crossing(0, 200, 3, 1, 2, 'h1234, 'hA001), -1);
        // Previous x beyond the line: neither the crossing nor the end draws.
        add_row(crossing(0, 32767, 0, 0, 9, 'h0001, 'h0000), 0);
        add_row(end_of_line(0), 0);
        // Four collide layers open, then closed in an order that leaves the
        // tracked pair naming a closed layer before it is repaired.
        add_row(crossing(32767, 1, 1, 1, 0, 'h00F0, 'h0101), 1, 0, 1, 0);
        add_row(crossing(32767, 2, 2, 1, 1, 'h0F00, 'h0202), -1);
        add_row(crossing(32767, 3, 4, 1, 5, 'hF000, 'h0505), -1);
        add_row(crossing(32767, 4, 5, 1, 7, 'h8001, 'h0707), -1);
        add_row(crossing(32767, 5, 1, 1, 0, 'h00F0, 'h0101), -1);
        add_row(crossing(32767, 6, 2, 1, 1, 'h0F00, 'h0202), -1);
        add_row(crossing(32767, 7, 4, 1, 5, 'hF000, 'h0505), -1);
        add_row(crossing(32767, 8, 5, 1, 7, 'h8001, 'h0707), -1);
        add_row(end_of_line(32767), 1, 8, 160, 0);
        // A collide layer reopened by a second polygon takes the newer id.
        add_row(crossing('h1555, 10, 6, 1, 3, 'h2222, 'h1111), -1);
        add_row(crossing('h1555, 20, 7, 1, 3, 'h4444, 'h3333), -1);
        add_row(crossing('h1555, 160, 8, 1, 12, 'h6666, 'h5555), -1);
        // Previous x at the line width: no span, but the collision still shows.
        add_row(crossing('h1555, 170, 9, 1, 12, 'h6666, 'h7777), -1);
        add_row(end_of_line('h1555), 0);
        // Negative previous x: the final span starts at 0.
        add_row(crossing('h2AAA, -5, 9, 0, 0, 'hABCD, 'h0000), 0);
        add_row(end_of_line('h2AAA), 1, 0, 160, 0);
    endtask

    function automatic int rand_x(int lw);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end else if (r < 12) begin
            case ($urandom_range(0, 5))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = lw;
                4: v = lw - 1;
                default: v = lw + 1;
            endcase
        end else begin
            v = int'($urandom_range(0, lw + 16)) - 8;
        end
        if (v > 32767) v = 32767;
        return v;
    endfunction

    // One random scanline: a few polygons, each giving an opening and a
    // closing crossing, sorted by x and mostly closed by an end of line. A small
    // share of lines is plain noise instead.
    task automatic gen_line();
        t_item edges[$];
        t_item tmp;
        t_row  row;
        int    y;
        int    np;
        int    k;
        int    z;
        int    ci;
        int    col;
        int    id;
        bit    cv;
        bit    saved_no_gap;
        saved_no_gap = no_gap;
        if ($urandom_range(0, 3) == 0) no_gap = 1'b1;
        row.n_typed = -1;
        row.xs      = 0;
        row.xe      = 0;
        row.col     = '0;
        y = $urandom_range(0, 32767);
        if ($urandom_range(0, 99) < 8) begin
            np = $urandom_range(1, 6);
            for (k = 0; k < np; k++) begin
                row.it = crossing($urandom_range(0, 32767),
                                  int'($urandom_range(0, 65535)) - 32768,
                                  $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 15), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
                row.it.req = 1'($urandom_range(0, 1));
                offer(row);
            end
        end else begin
            np = $urandom_range(1, 5);
            for (k = 0; k < np; k++) begin
                z   = $urandom_range(0, 15);
                cv  = ($urandom_range(0, 3) != 0);
                ci  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 15);
                col = $urandom_range(0, 65535);
                id  = $urandom_range(0, 65535);
                edges.push_back(crossing(y, rand_x(int'(line_width_q)), z, cv, ci, col, id));
                edges.push_back(crossing(y, rand_x(int'(line_width_q)), z, cv, ci, col, id));
            end
            for (int j = 1; j < edges.size(); j++) begin
                tmp = edges[j];
                k   = j - 1;
                while (k >= 0 && edges[k].x > tmp.x) begin
                    edges[k+1] = edges[k];
                    k--;
                end
                edges[k+1] = tmp;
            end
            foreach (edges[j]) begin
                row.it = edges[j];
                offer(row);
            end
            // Now and then a line runs on into the next one without its end.
            if ($urandom_range(0, 99) < 95) begin
                row.it = end_of_line(y);
                offer(row);
            end
        end
        no_gap = saved_no_gap;
    endtask

    // ------------------------------------------------------------------------
    // Output side. The receiver alternates ready and stalled runs of random
    // length, and on request holds tready low for a long stretch so that the
    // result queue fills and the block stops taking input.
    // ------------------------------------------------------------------------
    initial begin
        int run_left;
        int hold_left;
        int r;
        bit run_val;
        run_left  = 0;
        hold_left = 0;
        run_val   = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 20) begin
                        run_val  = 1'b1;
                        run_left = $urandom_range(40, 200);
                    end else if (r < 70) begin
                        run_val  = 1'b1;
                        run_left = $urandom_range(1, 8);
                    end else if (r < 95) begin
                        run_val  = 1'b0;
                        run_left = $urandom_range(1, 4);
                    end else begin
                        run_val  = 1'b0;
                        run_left = $urandom_range(10, 40);
                    end
                end
                run_left--;
                m_ready <= run_val;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: mismatch in %s: expected 0x%04h, got 0x%04h",
                     $time, name, want, got);
        end
    endtask

    // Every result taken by the receiver is compared with the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_valid && m_ready) begin
            got.kind           = m_user;
            got.line_y         = m_data[14:0];
            got.x_start        = m_data[30:15];
            got.x_end          = m_data[46:31];
            got.color          = m_data[62:47];
            got.collide_first  = m_data[66:63];
            got.collide_second = m_data[70:67];
            got.poly_first     = m_data[86:71];
            got.poly_second    = m_data[102:87];
            got.last           = m_last;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got kind %0d y %0d x %0d..%0d",
                         $time, got.kind, got.line_y, got.x_start, got.x_end);
            end else begin
                want = pending_results.pop_front();
                check_field("out_kind", 16'(want.kind), 16'(got.kind));
                check_field("line_y", 16'(want.line_y), 16'(got.line_y));
                check_field("x_start", want.x_start, got.x_start);
                check_field("x_end", want.x_end, got.x_end);
                check_field("slice_color", want.color, got.color);
                check_field("collide_first", 16'(want.collide_first),
                            16'(got.collide_first));
                check_field("collide_second", 16'(want.collide_second),
                            16'(got.collide_second));
                check_field("poly_first", want.poly_first, got.poly_first);
                check_field("poly_second", want.poly_second, got.poly_second);
                check_field("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    initial begin
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed rows, then random phases, each with its
    // own register setting written while the block is idle.
    // ------------------------------------------------------------------------
    initial begin
        logic [LWID_BITS-1:0]  lw;
        logic [COLOR_BITS-1:0] bg;
        int                    phase_end;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        line_width_q = LINE_WIDTH_RST;
        bg_color_q   = BG_COLOR_RST;
        for (int k = 0; k < 16; k++) begin
            layer_color[k] = '0;
            collide_id[k]  = '0;
        end
        clear_line_state();

        build_plan();
        foreach (plan[i]) offer(plan[i]);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            bg = COLOR_BITS'($urandom_range(0, 65535));
            case (p)
                0: begin
                    lw = 15'd1;
                    bg = 16'hFFFF;
                end
                1: lw = 15'd32767;
                2: lw = 15'd0;
                3: lw = LWID_BITS'($urandom_range(8, 64));
                4: begin
                    lw = 15'd160;
                    bg = 16'h0000;
                end
                5: lw = 15'd640;
                6: lw = LWID_BITS'($urandom_range(1, 32767));
                default: lw = 15'd3;
            endcase
            program_regs(lw, bg);
            // Two phases open with the receiver held off while the sender
            // streams without gaps, to fill the block and stall its input.
            if (p == 1 || p == 4) begin
                hold_off_req = 1'b1;
                burst_until  = n_sent + 60;
            end
            phase_end = n_sent + PHASE_ITEMS;
            while (n_sent < phase_end) gen_line();
            wait_idle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/lsr_pkg.sv
hdl/lsr_ram.sv
hdl/layered_span_resolver_core.sv
dv/tb_top.sv
